[rtl/core/tpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package tpp_pkg;

  localparam logic [7:0] HDR_OVERFLOW = 8'h70;
  localparam logic [7:0] SYNC_END     = 8'h80;
  localparam logic [7:0] HDR_PC_SLEEP = 8'h15;
  localparam logic [3:0] NIB_RSVD     = 4'h4;
  localparam logic [3:0] NIB_ITM_EXT  = 4'h8;
  localparam logic [3:0] NIB_TS_BASE  = 4'hc;
  localparam logic [2:0] TC_RESERVED  = 3'd4;
  localparam logic       REG_DUMP_PORT = 1'b0;

  localparam int unsigned TPP_QDEPTH = 2;
  localparam int unsigned QPTR_W     = $clog2(TPP_QDEPTH);
  localparam int unsigned QCNT_W     = $clog2(TPP_QDEPTH + 1);

  typedef enum logic [3:0] {
    KIND_SYNC     = 4'd0,
    KIND_BAD_SYNC = 4'd1,
    KIND_OVERFLOW = 4'd2,
    KIND_TS       = 4'd3,
    KIND_RESERVED = 4'd4,
    KIND_ITM_EXT  = 4'd5,
    KIND_DWT_EXT  = 4'd6,
    KIND_SW       = 4'd7,
    KIND_HW       = 4'd8,
    KIND_CHAR     = 4'd9
  } tpp_kind_e;

  typedef enum logic [3:0] {
    HW_OVF       = 4'd0,
    HW_EXC_ENTRY = 4'd1,
    HW_EXC_EXIT  = 4'd2,
    HW_EXC_RET   = 4'd3,
    HW_EXC_OTHER = 4'd4,
    HW_PC        = 4'd5,
    HW_PC_SLEEP  = 4'd6,
    HW_DATA_PC   = 4'd7,
    HW_ADDR_OFF  = 4'd8,
    HW_READ      = 4'd9,
    HW_WRITE     = 4'd10,
    HW_UNDEF     = 4'd11
  } tpp_hwcls_e;

  typedef enum logic [2:0] {
    CL_ZERO      = 3'd0,
    CL_OVERFLOW  = 3'd1,
    CL_TS_SHORT  = 3'd2,
    CL_TS_LONG   = 3'd3,
    CL_EXT_SHORT = 3'd4,
    CL_EXT_LONG  = 3'd5,
    CL_PAYLOAD   = 3'd6
  } tpp_cls_e;

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_SYNC = 5'b00010,
    PH_TS   = 5'b00100,
    PH_EXT  = 5'b01000,
    PH_PAY  = 5'b10000
  } tpp_phase_e;

  typedef struct packed {
    logic [7:0] data;
    tpp_cls_e   cls;
    logic [2:0] size;
  } tpp_tok_t;

  typedef struct packed {
    logic [3:0]  packet_kind;
    logic [7:0]  header_byte;
    logic [31:0] payload_value;
    logic [4:0]  source_id;
    logic [2:0]  payload_len;
    logic [2:0]  time_control;
    logic [3:0]  hw_event_class;
    logic [1:0]  comparator;
    logic [8:0]  exception_number;
    logic [5:0]  overflow_flags;
  } tpp_pkt_t;

endpackage

`default_nettype wire

[rtl/core/tpp_byte_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tpp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] trace_byte;

  modport source (output valid, output trace_byte, input ready);
  modport sink (input valid, input trace_byte, output ready);
endinterface

`default_nettype wire

[rtl/core/tpp_pkt_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface tpp_pkt_if;
  logic        valid;
  logic        ready;
  logic [3:0]  packet_kind;
  logic [7:0]  header_byte;
  logic [31:0] payload_value;
  logic [4:0]  source_id;
  logic [2:0]  payload_len;
  logic [2:0]  time_control;
  logic [3:0]  hw_event_class;
  logic [1:0]  comparator;
  logic [8:0]  exception_number;
  logic [5:0]  overflow_flags;

  modport source (
    output valid, output packet_kind, output header_byte, output payload_value,
    output source_id, output payload_len, output time_control,
    output hw_event_class, output comparator, output exception_number,
    output overflow_flags, input ready
  );
  modport sink (
    input valid, input packet_kind, input header_byte, input payload_value,
    input source_id, input payload_len, input time_control,
    input hw_event_class, input comparator, input exception_number,
    input overflow_flags, output ready
  );
endinterface

`default_nettype wire

[rtl/core/tpp_classify.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_classify (
  tpp_byte_if.sink          in_if,
  output logic              tok_valid_o,
  input  logic              tok_ready_i,
  output tpp_pkg::tpp_tok_t tok_o
);
  import tpp_pkg::*;

  logic [7:0] b;

  assign b           = in_if.trace_byte;
  assign tok_valid_o = in_if.valid;
  assign in_if.ready = tok_ready_i;

  always_comb begin
    tok_o.data = b;
    tok_o.size = (b[1:0] == 2'b11) ? 3'd4 : {1'b0, b[1:0]};
    priority if (b == 8'h00) begin
      tok_o.cls = CL_ZERO;
    end else if (b == HDR_OVERFLOW) begin
      tok_o.cls = CL_OVERFLOW;
    end else if (b[3:0] == 4'h0) begin
      tok_o.cls = b[7] ? CL_TS_LONG : CL_TS_SHORT;
    end else if (b[1:0] == 2'b00) begin
      tok_o.cls = b[7] ? CL_EXT_LONG : CL_EXT_SHORT;
    end else begin
      tok_o.cls = CL_PAYLOAD;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tpp_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  tpp_pkg::tpp_tok_t in_tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpp_pkg::tpp_tok_t out_tok_o
);
  import tpp_pkg::*;

  localparam logic [QPTR_W-1:0] PtrLast = QPTR_W'(TPP_QDEPTH - 1);
  localparam logic [QCNT_W-1:0] CntFull = QCNT_W'(TPP_QDEPTH);

  tpp_tok_t          mem_q [TPP_QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              push, pop;

  assign in_ready_o  = (cnt_q != CntFull);
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push) begin
      wr_d = (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
    end
    if (pop) begin
      rd_d = (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
    end
    unique case ({push, pop})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= in_tok_i;
    end
  end

endmodule

`default_nettype wire

[rtl/core/tpp_decode.sv]
`timescale 1ns / 1ps
`default_nettype none

module tpp_decode #(
  parameter int unsigned SYNC_ZEROS = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [5:0]        dump_port_i,
  input  logic              tok_valid_i,
  output logic              tok_ready_o,
  input  tpp_pkg::tpp_tok_t tok_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output tpp_pkg::tpp_pkt_t pkt_o
);
  import tpp_pkg::*;

  localparam int unsigned CNT_W = $clog2(SYNC_ZEROS + 1);
  localparam logic [CNT_W-1:0] SyncMax = CNT_W'(SYNC_ZEROS);

  tpp_phase_e       phase_q, phase_d;
  logic [7:0]       hdr_q, hdr_d;
  logic [31:0]      acc_q, acc_d;
  logic [2:0]       seen_q, seen_d;
  logic [2:0]       exp_q, exp_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q;
  tpp_pkt_t         out_q;
  logic             pop, res_vld;
  tpp_pkt_t         res;

  assign tok_ready_o = !out_valid_q || out_ready_i;
  assign pop         = tok_valid_i && tok_ready_o;
  assign out_valid_o = out_valid_q;
  assign pkt_o       = out_q;

  function automatic tpp_kind_e ext_kind(input logic [7:0] h);
    tpp_kind_e k;
    unique case (h[3:0])
      NIB_RSVD:    k = KIND_RESERVED;
      NIB_ITM_EXT: k = KIND_ITM_EXT;
      default:     k = KIND_DWT_EXT;
    endcase
    return k;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [31:0] bsh, tsh, acc_new;
    logic [2:0]  seen_new;
    logic [4:0]  typ;
    logic        go_idle;
    b        = tok_i.data;
    typ      = hdr_q[7:3];
    seen_new = seen_q + 3'd1;
    unique case (seen_q[1:0])
      2'd0: begin
        bsh = {24'b0, b};
        tsh = {25'b0, b[6:0]};
      end
      2'd1: begin
        bsh = {16'b0, b, 8'b0};
        tsh = {18'b0, b[6:0], 7'b0};
      end
      2'd2: begin
        bsh = {8'b0, b, 16'b0};
        tsh = {11'b0, b[6:0], 14'b0};
      end
      default: begin
        bsh = {b, 24'b0};
        tsh = {4'b0, b[6:0], 21'b0};
      end
    endcase
    acc_new = acc_q | (phase_q == PH_TS ? tsh : bsh);
    go_idle = 1'b0;
    phase_d = phase_q;
    hdr_d   = hdr_q;
    acc_d   = acc_q;
    seen_d  = seen_q;
    exp_d   = exp_q;
    cnt_d   = cnt_q;
    res_vld = 1'b0;
    res     = '0;

    if (pop) begin
      unique case (phase_q)
        PH_SYNC: begin
          if (cnt_q < SyncMax) begin
            if (b != 8'h00) begin
              go_idle           = 1'b1;
              res_vld           = 1'b1;
              res.packet_kind   = KIND_BAD_SYNC;
            end else begin
              cnt_d = cnt_q + 1'b1;
            end
          end else begin
            go_idle         = 1'b1;
            res_vld         = 1'b1;
            res.packet_kind = (b == SYNC_END) ? KIND_SYNC : KIND_BAD_SYNC;
          end
        end
        PH_TS: begin
          acc_d  = acc_new;
          seen_d = seen_new;
          if (!b[7] || seen_new[2]) begin
            go_idle = 1'b1;
            if (dump_port_i == '0) begin
              res_vld           = 1'b1;
              res.packet_kind   = KIND_TS;
              res.header_byte   = hdr_q;
              res.payload_value = acc_new;
              res.payload_len   = seen_new;
              res.time_control  = (hdr_q[7:4] >= NIB_TS_BASE) ?
                                  {1'b0, hdr_q[5:4]} : TC_RESERVED;
            end
          end
        end
        PH_EXT: begin
          acc_d  = acc_new;
          seen_d = seen_new;
          if (!b[7] || seen_new[2]) begin
            go_idle = 1'b1;
            if (dump_port_i == '0) begin
              res_vld           = 1'b1;
              res.packet_kind   = ext_kind(hdr_q);
              res.header_byte   = hdr_q;
              res.payload_value = acc_new;
              res.payload_len   = seen_new;
            end
          end
        end
        PH_PAY: begin
          acc_d  = acc_new;
          seen_d = seen_new;
          if (seen_new >= exp_q) begin
            go_idle           = 1'b1;
            res.header_byte   = hdr_q;
            res.payload_value = acc_new;
            res.source_id     = typ;
            res.payload_len   = seen_new;
            if (!hdr_q[2]) begin
              if (dump_port_i == '0) begin
                res_vld         = 1'b1;
                res.packet_kind = KIND_SW;
              end else if ({1'b0, typ} + 6'd1 == dump_port_i) begin
                res_vld           = 1'b1;
                res.packet_kind   = KIND_CHAR;
                res.payload_value = {24'b0, acc_new[7:0]};
              end
            end else if (dump_port_i == '0) begin
              res_vld         = 1'b1;
              res.packet_kind = KIND_HW;
              priority if (typ == 5'd0) begin
                res.hw_event_class = HW_OVF;
                res.overflow_flags = acc_new[5:0];
              end else if (typ == 5'd1) begin
                res.exception_number = acc_new[8:0];
                res.hw_event_class   = (acc_new[31:14] == '0 && acc_new[13:12] != 2'b00) ?
                                       {2'b00, acc_new[13:12]} : HW_EXC_OTHER;
              end else if (typ == 5'd2) begin
                res.hw_event_class = (hdr_q == HDR_PC_SLEEP) ? HW_PC_SLEEP : HW_PC;
              end else if (typ[4:3] == 2'b01) begin
                res.hw_event_class = typ[0] ? HW_ADDR_OFF : HW_DATA_PC;
                res.comparator     = hdr_q[5:4];
              end else if (typ[4:3] == 2'b10) begin
                res.hw_event_class = hdr_q[3] ? HW_WRITE : HW_READ;
                res.comparator     = hdr_q[5:4];
              end else begin
                res.hw_event_class = HW_UNDEF;
              end
            end
          end
        end
        default: begin
          go_idle = 1'b1;
          hdr_d   = b;
          unique case (tok_i.cls)
            CL_ZERO: begin
              phase_d = PH_SYNC;
              cnt_d   = CNT_W'(1);
            end
            CL_OVERFLOW: begin
              res_vld         = 1'b1;
              res.packet_kind = KIND_OVERFLOW;
              res.header_byte = b;
            end
            CL_TS_SHORT: begin
              if (dump_port_i == '0) begin
                res_vld           = 1'b1;
                res.packet_kind   = KIND_TS;
                res.header_byte   = b;
                res.payload_value = {28'b0, b[7:4]};
              end
            end
            CL_TS_LONG: begin
              phase_d = PH_TS;
            end
            CL_EXT_SHORT: begin
              if (dump_port_i == '0) begin
                res_vld         = 1'b1;
                res.packet_kind = ext_kind(b);
                res.header_byte = b;
              end
            end
            CL_EXT_LONG: begin
              phase_d = PH_EXT;
            end
            default: begin
              phase_d = PH_PAY;
            end
          endcase
        end
      endcase
      if (go_idle) begin
        if (phase_q != PH_IDLE || tok_i.cls == CL_OVERFLOW ||
            tok_i.cls == CL_TS_SHORT || tok_i.cls == CL_EXT_SHORT) begin
          phase_d = PH_IDLE;
        end
        acc_d  = '0;
        seen_d = '0;
        exp_d  = (phase_q == PH_IDLE && tok_i.cls == CL_PAYLOAD) ? tok_i.size : 3'd0;
        if (phase_q == PH_IDLE && tok_i.cls == CL_ZERO) begin
          cnt_d = CNT_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      out_valid_q <= 1'b0;
      hdr_q       <= '0;
      acc_q       <= '0;
      seen_q      <= '0;
      exp_q       <= '0;
      cnt_q       <= '0;
    end else begin
      phase_q <= phase_d;
      hdr_q   <= hdr_d;
      acc_q   <= acc_d;
      seen_q  <= seen_d;
      exp_q   <= exp_d;
      cnt_q   <= cnt_d;
      if (tok_ready_o) begin
        out_valid_q <= pop && res_vld;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop && res_vld) begin
      out_q <= res;
    end
  end

endmodule

`default_nettype wire

[rtl/core/itm_dwt_trace_packet_parser.sv]
// Trace packet parser for a serial-wire trace byte stream.
// in_if carries one trace byte per transfer; out_if carries one decoded packet
// per transfer, and only bytes that complete a packet give one. The APB port
// holds dump_port at byte address 0: zero gives full decode, n keeps only the
// low payload byte of software port n-1 (sync, bad sync and overflow are kept).
// Write dump_port only while no packet is in progress.
// Throughput: one byte per cycle while the receiver does not stall, set by the
// decoder state register behind a two-entry byte queue.
// Each byte passes the queue and then the decoder; the output register takes a
// result when the decoder takes the byte that completes its packet.
// Reset: decoder idle awaiting a header, queue empty, dump_port zero.
// When the receiver stalls, the output register holds its packet, the decoder
// stops, the queue takes at most two more transfers and in_if.ready drops;
// no byte or packet is lost.
`timescale 1ns / 1ps
`default_nettype none

module itm_dwt_trace_packet_parser #(
  parameter int unsigned SYNC_ZEROS = 7
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  tpp_byte_if.sink    in_if,
  tpp_pkt_if.source   out_if
);
  import tpp_pkg::*;

  logic [5:0] dump_q;
  logic       ftok_valid, ftok_ready;
  tpp_tok_t   ftok;
  logic       btok_valid, btok_ready;
  tpp_tok_t   btok;
  tpp_pkt_t   pkt;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_DUMP_PORT) ? {26'b0, dump_q} : 32'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dump_q <= '0;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_DUMP_PORT) begin
      dump_q <= pwdata[5:0];
    end
  end

  tpp_classify u_classify (
    .in_if       (in_if),
    .tok_valid_o (ftok_valid),
    .tok_ready_i (ftok_ready),
    .tok_o       (ftok)
  );

  tpp_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (ftok_valid),
    .in_ready_o  (ftok_ready),
    .in_tok_i    (ftok),
    .out_valid_o (btok_valid),
    .out_ready_i (btok_ready),
    .out_tok_o   (btok)
  );

  tpp_decode #(
    .SYNC_ZEROS (SYNC_ZEROS)
  ) u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dump_port_i (dump_q),
    .tok_valid_i (btok_valid),
    .tok_ready_o (btok_ready),
    .tok_i       (btok),
    .out_valid_o (out_if.valid),
    .out_ready_i (out_if.ready),
    .pkt_o       (pkt)
  );

  assign out_if.packet_kind      = pkt.packet_kind;
  assign out_if.header_byte      = pkt.header_byte;
  assign out_if.payload_value    = pkt.payload_value;
  assign out_if.source_id        = pkt.source_id;
  assign out_if.payload_len      = pkt.payload_len;
  assign out_if.time_control     = pkt.time_control;
  assign out_if.hw_event_class   = pkt.hw_event_class;
  assign out_if.comparator       = pkt.comparator;
  assign out_if.exception_number = pkt.exception_number;
  assign out_if.overflow_flags   = pkt.overflow_flags;

endmodule

`default_nettype wire

[tb/tb_itm_dwt_trace_packet_parser.sv]
`timescale 1ns / 1ps

module tb_itm_dwt_trace_packet_parser;
  import tpp_pkg::*;

  localparam int unsigned ZERO_RUN      = 7;
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam int unsigned QUIET_LIMIT   = 3000;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tpp_byte_if in_if ();
  tpp_pkt_if  out_if ();

  itm_dwt_trace_packet_parser #(
    .SYNC_ZEROS(ZERO_RUN)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .in_if  (in_if),
    .out_if (out_if)
  );

  // decoder tracking state
  logic [5:0]  dump_sel    = '0;
  tpp_phase_e  trk_phase   = PH_IDLE;
  logic [7:0]  trk_hdr     = '0;
  logic [31:0] trk_acc     = '0;
  logic [2:0]  trk_seen    = '0;
  logic [2:0]  trk_need    = '0;
  tpp_pkt_t    pending_pkts[$];
  tpp_pkt_t    oldest_pkt;

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned bytes_sent     = 0;
  int unsigned mismatches     = 0;
  int unsigned quiet_cycles   = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  function automatic tpp_pkt_t make_pkt(input logic [3:0] kind, input logic [7:0] hdr,
                                        input logic [31:0] val);
    tpp_pkt_t p;
    p = '0;
    p.packet_kind   = kind;
    p.header_byte   = hdr;
    p.payload_value = val;
    return p;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    tpp_pkt_t    p;
    tpp_hwcls_e  cls;
    logic [7:0]  hdr;
    logic [31:0] val;
    logic [2:0]  len;
    logic [4:0]  src;
    logic [19:0] fn;
    logic        hit;
    logic        fin_ts;
    logic        fin_ext;
    logic        fin_pay;
    p       = '0;
    hit     = 1'b0;
    fin_ts  = 1'b0;
    fin_ext = 1'b0;
    fin_pay = 1'b0;
    case (trk_phase)
      PH_SYNC: begin
        if (trk_acc < ZERO_RUN && b != 8'h00) begin
          trk_phase = PH_IDLE;
          trk_acc   = '0;
          p   = make_pkt(KIND_BAD_SYNC, 8'h00, 32'd0);
          hit = 1'b1;
        end else if (trk_acc < ZERO_RUN) begin
          trk_acc = trk_acc + 32'd1;
        end else begin
          trk_phase = PH_IDLE;
          trk_acc   = '0;
          p   = make_pkt((b == SYNC_END) ? KIND_SYNC : KIND_BAD_SYNC, 8'h00, 32'd0);
          hit = 1'b1;
        end
      end
      PH_TS: begin
        trk_acc  = trk_acc | (32'(b[6:0]) << (7 * trk_seen[1:0]));
        trk_seen = trk_seen + 3'd1;
        fin_ts   = !b[7] || trk_seen >= 3'd4;
      end
      PH_EXT: begin
        trk_acc  = trk_acc | (32'(b) << (8 * trk_seen[1:0]));
        trk_seen = trk_seen + 3'd1;
        fin_ext  = !b[7] || trk_seen >= 3'd4;
      end
      PH_PAY: begin
        trk_acc  = trk_acc | (32'(b) << (8 * trk_seen[1:0]));
        trk_seen = trk_seen + 3'd1;
        fin_pay  = trk_seen >= trk_need;
      end
      default: begin
        trk_phase = PH_IDLE;
        trk_acc   = '0;
        trk_seen  = '0;
        trk_need  = '0;
        trk_hdr   = b;
        if (b == 8'h00) begin
          trk_phase = PH_SYNC;
          trk_acc   = 32'd1;
        end else if (b == HDR_OVERFLOW) begin
          p   = make_pkt(KIND_OVERFLOW, b, 32'd0);
          hit = 1'b1;
        end else if (b[3:0] == 4'h0) begin
          if (!b[7]) begin
            if (dump_sel == 6'd0) begin
              p   = make_pkt(KIND_TS, b, {28'd0, b[7:4]});
              hit = 1'b1;
            end
          end else begin
            trk_phase = PH_TS;
          end
        end else if (b[3:0] == NIB_RSVD || b[3:0] == NIB_ITM_EXT || b[3:0] == NIB_TS_BASE) begin
          if (!b[7]) fin_ext = 1'b1;
          else trk_phase = PH_EXT;
        end else begin
          trk_phase = PH_PAY;
          trk_need  = (b[1:0] == 2'd3) ? 3'd4 : {1'b0, b[1:0]};
        end
      end
    endcase

    if (fin_ts || fin_ext || fin_pay) begin
      hdr = trk_hdr;
      val = trk_acc;
      len = trk_seen;
      src = hdr[7:3];
      trk_phase = PH_IDLE;
      trk_acc   = '0;
      trk_seen  = '0;
      trk_need  = '0;
      if (fin_ts && dump_sel == 6'd0) begin
        p = make_pkt(KIND_TS, hdr, val);
        p.payload_len  = len;
        p.time_control = (hdr[7:4] >= NIB_TS_BASE) ? 3'(hdr[7:4] - NIB_TS_BASE) : TC_RESERVED;
        hit = 1'b1;
      end
      if (fin_ext && dump_sel == 6'd0) begin
        p = make_pkt((hdr[3:0] == NIB_RSVD) ? KIND_RESERVED :
                     ((hdr[3:0] == NIB_ITM_EXT) ? KIND_ITM_EXT : KIND_DWT_EXT), hdr, val);
        p.payload_len = len;
        hit = 1'b1;
      end
      if (fin_pay && !hdr[2]) begin
        if (dump_sel == 6'd0) begin
          p   = make_pkt(KIND_SW, hdr, val);
          hit = 1'b1;
        end else if ({1'b0, src} + 6'd1 == dump_sel) begin
          p   = make_pkt(KIND_CHAR, hdr, {24'd0, val[7:0]});
          hit = 1'b1;
        end
        p.source_id   = hit ? src : 5'd0;
        p.payload_len = hit ? len : 3'd0;
      end
      if (fin_pay && hdr[2] && dump_sel == 6'd0) begin
        p = make_pkt(KIND_HW, hdr, val);
        p.source_id   = src;
        p.payload_len = len;
        fn = val[31:12];
        if (src == 5'd0) begin
          cls = HW_OVF;
          p.overflow_flags = val[5:0];
        end else if (src == 5'd1) begin
          if (fn == 20'd1) cls = HW_EXC_ENTRY;
          else if (fn == 20'd2) cls = HW_EXC_EXIT;
          else if (fn == 20'd3) cls = HW_EXC_RET;
          else cls = HW_EXC_OTHER;
          p.exception_number = val[8:0];
        end else if (src == 5'd2) begin
          cls = (hdr == HDR_PC_SLEEP) ? HW_PC_SLEEP : HW_PC;
        end else if (src[4:3] == 2'b01) begin
          cls = src[0] ? HW_ADDR_OFF : HW_DATA_PC;
          p.comparator = hdr[5:4];
        end else if (src[4:3] == 2'b10) begin
          cls = hdr[3] ? HW_WRITE : HW_READ;
          p.comparator = hdr[5:4];
        end else begin
          cls = HW_UNDEF;
        end
        p.hw_event_class = cls;
        hit = 1'b1;
      end
    end
    if (hit) pending_pkts.push_back(p);
  endtask

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.trace_byte <= b;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_seq(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  // continuation bytes: all but the last carry bit 7, the fourth ends regardless
  task automatic send_groups(input int n);
    logic [7:0] cb;
    for (int i = 0; i < n; i++) begin
      cb    = 8'($urandom);
      cb[7] = (i < n - 1) ? 1'b1 : ((i == 3) ? cb[7] : 1'b0);
      send_byte(cb);
    end
  endtask

  task automatic drain_stream();
    while (trk_phase != PH_IDLE) begin
      send_byte((trk_phase == PH_PAY) ? 8'($urandom) :
                ((trk_phase == PH_SYNC) ? 8'h01 : 8'h00));
    end
    in_if.valid <= 1'b0;
    while (pending_pkts.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_dump_port(input logic [5:0] dp);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_DUMP_PORT, 2'b00};
    pwdata  <= {26'($urandom), dp};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    dump_sel = dp;
  endtask

  task automatic set_profile(input int k);
    case (k % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
      default: begin send_idle_pct = 34; recv_stall_pct = 34; end
    endcase
  endtask

  task automatic send_random_packet();
    int unsigned pick;
    int          n;
    logic [7:0]  hdr;
    logic [7:0]  tail;
    logic [4:0]  src;
    logic [1:0]  sz;
    pick = $urandom_range(99);
    if (pick < 10) begin
      send_byte(8'($urandom));
    end else if (pick < 22) begin
      if ($urandom_range(3) != 0) begin
        repeat (ZERO_RUN) send_byte(8'h00);
        send_byte(SYNC_END);
      end else begin
        n = $urandom_range(1, ZERO_RUN);
        repeat (n) send_byte(8'h00);
        tail = 8'($urandom_range(1, 255));
        if (tail == SYNC_END) tail = 8'hff;
        send_byte(tail);
      end
    end else if (pick < 27) begin
      send_byte(HDR_OVERFLOW);
    end else if (pick < 33) begin
      send_byte({1'b0, 3'($urandom_range(1, 6)), 4'h0});
    end else if (pick < 45) begin
      send_byte({1'b1, 3'($urandom), 4'h0});
      send_groups($urandom_range(1, 4));
    end else if (pick < 55) begin
      hdr = {4'($urandom), 4'h0};
      case ($urandom_range(2))
        0: hdr[3:0] = NIB_RSVD;
        1: hdr[3:0] = NIB_ITM_EXT;
        default: hdr[3:0] = NIB_TS_BASE;
      endcase
      send_byte(hdr);
      if (hdr[7]) send_groups($urandom_range(1, 4));
    end else begin
      sz = 2'($urandom_range(1, 3));
      if (pick < 78) begin
        src = (dump_sel != 6'd0 && dump_sel <= 6'd32 && $urandom_range(1) == 1) ?
              5'(dump_sel - 6'd1) : 5'($urandom);
        hdr = {src, 1'b0, sz};
      end else begin
        src = ($urandom_range(2) == 0) ? 5'($urandom_range(2)) : 5'($urandom);
        hdr = {src, 1'b1, sz};
        if (src == 5'd2 && $urandom_range(1) == 1) hdr = HDR_PC_SLEEP;
      end
      send_byte(hdr);
      n = (hdr[1:0] == 2'd3) ? 4 : int'(hdr[1:0]);
      repeat (n) send_byte(8'($urandom));
    end
  endtask

  task automatic run_random(input int unsigned count);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < count) send_random_packet();
    drain_stream();
  endtask

  task automatic test_directed_decode();
    set_profile(0);
    write_dump_port(6'd0);
    send_seq('{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h80,
               8'h00, 8'h00, 8'h5a,
               HDR_OVERFLOW, 8'h10,
               8'hf0, 8'hff, 8'hff, 8'hff, 8'hff,
               8'h84, 8'hff, 8'hff, 8'hff, 8'hff,
               8'h0c,
               8'hfb, 8'hff, 8'hff, 8'hff, 8'hff});
    drain_stream();
  endtask

  task automatic test_directed_dump();
    set_profile(3);
    write_dump_port(6'd1);
    send_seq('{8'h01, 8'h41, 8'h0a, 8'h42, 8'h43, 8'h0e, 8'h01, 8'h20,
               8'h20, HDR_OVERFLOW});
    drain_stream();
  endtask

  task automatic test_random_decode();
    write_dump_port(6'd0);
    for (int k = 0; k < 4; k++) begin
      set_profile(k);
      run_random(70);
    end
  endtask

  task automatic test_random_dump();
    logic [5:0] dp;
    for (int k = 0; k < 5; k++) begin
      case (k)
        0: dp = 6'd1;
        1: dp = 6'd32;
        2: dp = 6'd63;
        3: dp = 6'($urandom_range(2, 31));
        default: dp = 6'($urandom_range(33, 62));
      endcase
      write_dump_port(dp);
      set_profile(k);
      run_random(45);
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got 0x%0h, want 0x%0h", what, got, want);
    mismatches++;
  endtask

  task automatic compare_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_pkts.size() == 0) begin
        report_mismatch("unexpected packet kind", 32'(out_if.packet_kind), 32'd0);
      end else begin
        oldest_pkt = pending_pkts.pop_front();
        compare_field("packet_kind", 32'(out_if.packet_kind), 32'(oldest_pkt.packet_kind));
        compare_field("header_byte", 32'(out_if.header_byte), 32'(oldest_pkt.header_byte));
        compare_field("payload_value", out_if.payload_value, oldest_pkt.payload_value);
        compare_field("source_id", 32'(out_if.source_id), 32'(oldest_pkt.source_id));
        compare_field("payload_len", 32'(out_if.payload_len), 32'(oldest_pkt.payload_len));
        compare_field("time_control", 32'(out_if.time_control),
                      32'(oldest_pkt.time_control));
        compare_field("hw_event_class", 32'(out_if.hw_event_class),
                      32'(oldest_pkt.hw_event_class));
        compare_field("comparator", 32'(out_if.comparator), 32'(oldest_pkt.comparator));
        compare_field("exception_number", 32'(out_if.exception_number),
                      32'(oldest_pkt.exception_number));
        compare_field("overflow_flags", 32'(out_if.overflow_flags),
                      32'(oldest_pkt.overflow_flags));
      end
    end
  end

  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_ni           <= 1'b0;
    in_if.valid      <= 1'b0;
    in_if.trace_byte <= 8'h00;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_decode();
    test_directed_dump();
    test_random_decode();
    test_random_dump();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
